@@ sv/ampq_pkg.sv @@
package ampq_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned FILL_W = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_POP  = 2'd1,
		FUNC_PEEK = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	// one queue entry as held in the store
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

endpackage

@@ sv/ampq_if.sv @@
interface ampq_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [ampq_pkg::FUNC_W-1:0]           func;
	logic signed [ampq_pkg::DATA_W-1:0]    item_data;
	logic signed [ampq_pkg::DATA_W-1:0]    item_priority;

	modport source (output valid, output func, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input func, input item_data, input item_priority,
		output ready);
endinterface

interface ampq_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [ampq_pkg::STAT_W-1:0]           status;
	logic signed [ampq_pkg::DATA_W-1:0]    top_data;
	logic signed [ampq_pkg::DATA_W-1:0]    top_priority;
	logic [ampq_pkg::FILL_W-1:0]           fill_count;

	modport source (output valid, output status, output top_data, output top_priority,
		output fill_count, input ready);
	modport sink (input valid, input status, input top_data, input top_priority,
		input fill_count, output ready);
endinterface

@@ sv/array_max_priority_queue_core.sv @@
// max priority queue held unsorted in a single-port-write / single-port-read store
//
// req channel (valid/ready): func selects push, pop highest or peek highest;
// item_data and item_priority only matter for a push. rsp channel (valid/ready)
// returns exactly one result per request: status, the chosen entry for pop or
// peek (zero otherwise) and the fill count after the request (low 8 bits).
//
// one request is in flight at a time: req.ready is high only while idle.
// push, a pop or peek on an empty queue and the unused code skip the scan and
// go from accept to the done state. peek scans every held entry: the shared compare
// unit sees one entry per cycle behind the registered store read port. pop adds
// a shift pass that moves the entries above the chosen slot down by one; the
// one read and one write port of the store set both passes.
//
// reset clears the count and all control; store contents stay undefined and
// are never read below the count before being written. when the receiver
// stalls the result holds in the output register and the block waits with the
// next result until it is taken.
module array_max_priority_queue_core #(
	parameter int unsigned DEPTH = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	ampq_req_if.sink      req,
	ampq_rsp_if.source    rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	ampq_pkg::func_t            op_q;
	logic [AW-1:0]              iss_q;       // read address being issued
	logic                       issuing_q;
	logic [AW-1:0]              last_q;      // index of the last held entry
	logic                       pv_s1;       // read data valid this cycle
	logic [AW-1:0]              pidx_s1;     // index of that read data
	logic [AW-1:0]              best_idx_q;
	ampq_pkg::entry_t           best_q;
	ampq_pkg::status_t          res_status_q;
	ampq_pkg::entry_t           res_top_q;

	logic                       out_v_q;
	ampq_pkg::status_t          out_status_q;
	ampq_pkg::entry_t           out_top_q;
	logic [ampq_pkg::FILL_W-1:0] out_fill_q;

	logic                       accept;
	logic                       full;
	logic                       load_out;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	ampq_pkg::entry_t           mem_wdata;
	ampq_pkg::entry_t           mem_rdata;
	ampq_pkg::entry_t           push_entry;
	logic                       take;
	ampq_pkg::entry_t           nb;
	logic [AW-1:0]              nb_idx;
	logic                       scan_end;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));

	// result moves into the output register once that register is free
	assign load_out  = (state_q == S_DONE) && (!out_v_q || rsp.ready);

	assign push_entry.data = req.item_data;
	assign push_entry.prio = req.item_priority;

	// store write: appended entry on push, moved entry during the shift pass
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = push_entry;
		if (state_q == S_SHIFT) begin
			mem_we    = pv_s1;
			mem_waddr = AW'(pidx_s1 - 1'b1);
			mem_wdata = mem_rdata;
		end else if (accept && (ampq_pkg::func_t'(req.func) == ampq_pkg::FUNC_PUSH)
				&& !full) begin
			mem_we = 1'b1;
		end
	end

	ampq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (iss_q),
		.rdata (mem_rdata)
	);

	// shared compare unit, one entry per cycle
	ampq_cmp u_cmp (
		.cand  (mem_rdata),
		.best  (best_q),
		.first (pidx_s1 == '0),
		.take  (take)
	);

	assign nb       = take ? mem_rdata : best_q;
	assign nb_idx   = take ? pidx_s1 : best_idx_q;
	assign scan_end = pv_s1 && (pidx_s1 == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			op_q         <= ampq_pkg::FUNC_NOP;
			iss_q        <= '0;
			issuing_q    <= 1'b0;
			last_q       <= '0;
			pv_s1        <= 1'b0;
			pidx_s1      <= '0;
			best_idx_q   <= '0;
			best_q       <= '0;
			res_status_q <= ampq_pkg::STAT_OK;
			res_top_q    <= '0;
			out_v_q      <= 1'b0;
			out_status_q <= ampq_pkg::STAT_OK;
			out_top_q    <= '0;
			out_fill_q   <= '0;
		end else begin
			// output register: loads a finished result, else drains when taken
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			// read issue pipeline shared by scan and shift
			if (issuing_q) begin
				pv_s1   <= 1'b1;
				pidx_s1 <= iss_q;
				if (iss_q == last_q) begin
					issuing_q <= 1'b0;
				end else begin
					iss_q <= AW'(iss_q + 1'b1);
				end
			end else begin
				pv_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= ampq_pkg::func_t'(req.func);
						res_top_q <= '0;
						res_status_q <= ampq_pkg::STAT_OK;
						state_q   <= S_DONE;
						case (ampq_pkg::func_t'(req.func))
							ampq_pkg::FUNC_PUSH: begin
								if (full) begin
									res_status_q <= ampq_pkg::STAT_FULL;
								end else begin
									count_q <= CW'(count_q + 1'b1);
								end
							end
							ampq_pkg::FUNC_POP, ampq_pkg::FUNC_PEEK: begin
								if (count_q == '0) begin
									res_status_q <= ampq_pkg::STAT_EMPTY;
								end else begin
									last_q    <= AW'(count_q - 1'b1);
									iss_q     <= '0;
									issuing_q <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (pv_s1) begin
						best_q     <= nb;
						best_idx_q <= nb_idx;
					end
					if (scan_end) begin
						res_top_q <= nb;
						if (op_q == ampq_pkg::FUNC_PEEK) begin
							state_q <= S_DONE;
						end else if (nb_idx == last_q) begin
							count_q <= CW'(count_q - 1'b1);
							state_q <= S_DONE;
						end else begin
							// close the gap: move entries above the winner down by one
							iss_q     <= AW'(nb_idx + 1'b1);
							issuing_q <= 1'b1;
							state_q   <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (pv_s1 && (pidx_s1 == last_q)) begin
						count_q <= CW'(count_q - 1'b1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_status_q <= res_status_q;
						out_top_q    <= res_top_q;
						out_fill_q   <= ampq_pkg::FILL_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_status_q;
	assign rsp.top_data     = out_top_q.data;
	assign rsp.top_priority = out_top_q.prio;
	assign rsp.fill_count   = out_fill_q;

endmodule

@@ sv/ampq_mem.sv @@
module ampq_mem #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  ampq_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output ampq_pkg::entry_t          rdata
);

	ampq_pkg::entry_t mem_q [DEPTH];
	ampq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ampq_cmp.sv @@
module ampq_cmp (
	input  ampq_pkg::entry_t cand,
	input  ampq_pkg::entry_t best,
	input  logic             first,
	output logic             take
);

	// higher priority wins, then larger data; a tie keeps the earlier entry
	always_comb begin
		take = first
			|| (cand.prio > best.prio)
			|| ((cand.prio == best.prio) && (cand.data > best.data));
	end

endmodule

@@ sv/ampq_checker.sv @@
module ampq_checker #(
	parameter int unsigned DEPTH = 128
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [ampq_pkg::STAT_W-1:0]        status,
	input logic signed [ampq_pkg::DATA_W-1:0] top_data,
	input logic signed [ampq_pkg::DATA_W-1:0] top_priority,
	input logic [ampq_pkg::FILL_W-1:0]        fill_count
);

	// a result waits for the receiver
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_count))
		else $error("result dropped or changed while stalled");

	// one request at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// empty and full results carry no entry
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ampq_pkg::STAT_EMPTY || status == ampq_pkg::STAT_FULL)
		|-> top_data == '0 && top_priority == '0)
		else $error("entry on empty or full result");

	// full is reported only at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ampq_pkg::STAT_FULL
		|-> fill_count == ampq_pkg::FILL_W'(DEPTH))
		else $error("full reported below capacity");

	// empty is reported only with no entries
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ampq_pkg::STAT_EMPTY |-> fill_count == '0
		|| DEPTH > 255)
		else $error("empty reported with entries held");

endmodule

bind array_max_priority_queue_core ampq_checker #(.DEPTH(DEPTH)) u_ampq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.status       (rsp.status),
	.top_data     (rsp.top_data),
	.top_priority (rsp.top_priority),
	.fill_count   (rsp.fill_count)
);

@@ bench/tb_array_max_priority_queue_core.sv @@
module tb_array_max_priority_queue_core;

	localparam int unsigned DEPTH       = 128;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// slowest request: full scan plus full shift pass, with some margin
	localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 20;
	localparam int unsigned MAX_REPORTS   = 40;
	localparam logic signed [ampq_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [ampq_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	// one result as the block should return it
	typedef struct {
		logic [ampq_pkg::STAT_W-1:0]        status;
		logic signed [ampq_pkg::DATA_W-1:0] top_data;
		logic signed [ampq_pkg::DATA_W-1:0] top_prio;
		logic [ampq_pkg::FILL_W-1:0]        fill;
	} outcome_t;

	logic clk;
	logic arst_n;

	ampq_req_if req_ch ();
	ampq_rsp_if rsp_ch ();

	array_max_priority_queue_core #(
		.DEPTH (DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the queue contents, in slot order
	logic signed [ampq_pkg::DATA_W-1:0] held_data[$];
	logic signed [ampq_pkg::DATA_W-1:0] held_prio[$];
	// results owed by the block, oldest first
	outcome_t                 pending_results[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned stall_left;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a stuck handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: ready drops for random bursts, never once the calm tail starts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) == 0)
				stall_left <= $urandom_range(1, 18);
		end
	end

	// works out what one accepted request returns and updates the shadow queue
	function automatic outcome_t predict_outcome(ampq_pkg::func_t f,
			logic signed [ampq_pkg::DATA_W-1:0] d, logic signed [ampq_pkg::DATA_W-1:0] p);
		outcome_t    res;
		int unsigned best;
		res.status   = ampq_pkg::STAT_OK;
		res.top_data = '0;
		res.top_prio = '0;
		case (f)
			ampq_pkg::FUNC_PUSH: begin
				if (held_data.size() >= DEPTH) begin
					res.status = ampq_pkg::STAT_FULL;
				end else begin
					held_data.push_back(d);
					held_prio.push_back(p);
				end
			end
			ampq_pkg::FUNC_POP, ampq_pkg::FUNC_PEEK: begin
				if (held_data.size() == 0) begin
					res.status = ampq_pkg::STAT_EMPTY;
				end else begin
					// higher priority wins, then larger data, then the earlier slot
					best = 0;
					for (int unsigned i = 1; i < held_data.size(); i++) begin
						if (held_prio[i] > held_prio[best])
							best = i;
						else if (held_prio[i] == held_prio[best] && held_data[i] > held_data[best])
							best = i;
					end
					res.top_data = held_data[best];
					res.top_prio = held_prio[best];
					if (f == ampq_pkg::FUNC_POP) begin
						held_data.delete(best);
						held_prio.delete(best);
					end
				end
			end
			default: ;
		endcase
		res.fill = ampq_pkg::FILL_W'(held_data.size());
		return res;
	endfunction

	// words biased toward the extremes and a narrow band so ties are common
	function automatic logic signed [ampq_pkg::DATA_W-1:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return -1;
			3, 4, 5: return $urandom_range(0, 6) - 3;
			default: return $urandom();
		endcase
	endfunction

	// drives one request from a falling edge and returns at the falling edge after
	// acceptance; valid stays high so back-to-back requests need no extra step
	task automatic send_request(input ampq_pkg::func_t f,
			input logic signed [ampq_pkg::DATA_W-1:0] d,
			input logic signed [ampq_pkg::DATA_W-1:0] p);
		int unsigned gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.func          <= f;
		req_ch.item_data     <= d;
		req_ch.item_priority <= p;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.push_back(predict_outcome(f, d, p));
		@(negedge clk);
	endtask

	task automatic send_random(input ampq_pkg::func_t f);
		send_request(f, pick_word(), pick_word());
	endtask

	// sender holds off until every owed result has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic flag_mismatch(input string field, input logic [ampq_pkg::DATA_W-1:0] want,
			input logic [ampq_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		end
	endtask

	// result checker: every accepted response against the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none actual status %0h", $time,
						rsp_ch.status);
			end else begin
				want = pending_results.pop_front();
				flag_mismatch("status", ampq_pkg::DATA_W'(want.status),
					ampq_pkg::DATA_W'(rsp_ch.status));
				flag_mismatch("top_data", want.top_data, rsp_ch.top_data);
				flag_mismatch("top_priority", want.top_prio, rsp_ch.top_priority);
				flag_mismatch("fill_count", ampq_pkg::DATA_W'(want.fill),
					ampq_pkg::DATA_W'(rsp_ch.fill_count));
			end
		end
	end

	// pop, peek and the unused code on an empty queue
	task automatic test_empty_queue();
		send_random(ampq_pkg::FUNC_POP);
		send_random(ampq_pkg::FUNC_PEEK);
		send_random(ampq_pkg::FUNC_NOP);
		drain_results();
	endtask

	// extreme words, the most negative priority and the tie-break order
	task automatic test_extremes();
		// a lone entry at the most negative priority is still chosen
		send_request(ampq_pkg::FUNC_PUSH, WORD_MIN, WORD_MIN);
		send_request(ampq_pkg::FUNC_PEEK, WORD_MAX, WORD_MAX);
		send_request(ampq_pkg::FUNC_POP, '0, '0);
		// several entries at the most negative priority, data decides
		send_request(ampq_pkg::FUNC_PUSH, 3, WORD_MIN);
		send_request(ampq_pkg::FUNC_PUSH, -5, WORD_MIN);
		send_request(ampq_pkg::FUNC_PUSH, 7, WORD_MIN);
		send_request(ampq_pkg::FUNC_POP, WORD_MIN, WORD_MIN);
		send_request(ampq_pkg::FUNC_POP, -1, -1);
		send_request(ampq_pkg::FUNC_POP, '0, '0);
		// equal priority: larger data first, duplicates leave in slot order
		send_request(ampq_pkg::FUNC_PUSH, 0, 7);
		send_request(ampq_pkg::FUNC_PUSH, 9, 7);
		send_request(ampq_pkg::FUNC_PUSH, 9, 7);
		send_request(ampq_pkg::FUNC_PUSH, WORD_MAX, WORD_MAX);
		send_request(ampq_pkg::FUNC_PUSH, -1, -1);
		send_request(ampq_pkg::FUNC_NOP, WORD_MAX, WORD_MIN);
		send_request(ampq_pkg::FUNC_PEEK, '0, '0);
		repeat (6) send_random(ampq_pkg::FUNC_POP);
		drain_results();
	endtask

	// fill to the brim, one push too many, then empty it again
	task automatic test_full_queue();
		repeat (DEPTH) send_random(ampq_pkg::FUNC_PUSH);
		send_random(ampq_pkg::FUNC_PUSH);
		send_random(ampq_pkg::FUNC_NOP);
		send_random(ampq_pkg::FUNC_PEEK);
		repeat (DEPTH + 1) send_random(ampq_pkg::FUNC_POP);
		drain_results();
	endtask

	// random mix in phases that lean toward filling, draining or neither
	task automatic test_random_mix(input int unsigned count);
		int unsigned mode;
		int unsigned push_pct;
		int unsigned pop_pct;
		int unsigned roll;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				mode = $urandom_range(0, 2);
				push_pct = (mode == 0) ? 45 : (mode == 1) ? 75 : 25;
				pop_pct  = (mode == 2) ? 55 : 15 + (75 - push_pct) / 2;
			end
			// one full pause mid-run, then the quiet tail with no idling at all
			if (n == count / 2)
				drain_results();
			if (n == count - 150)
				calm = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				send_random(ampq_pkg::FUNC_NOP);
			else if (roll < 3 + push_pct)
				send_random(ampq_pkg::FUNC_PUSH);
			else if (roll < 3 + push_pct + pop_pct)
				send_random(ampq_pkg::FUNC_POP);
			else
				send_random(ampq_pkg::FUNC_PEEK);
		end
		drain_results();
	endtask

	initial begin
		error_count          = 0;
		cycle_count          = 0;
		stall_left           = 0;
		calm                 = 1'b0;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.func          = ampq_pkg::FUNC_NOP;
		req_ch.item_data     = '0;
		req_ch.item_priority = '0;
		rsp_ch.ready         = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_extremes();
		test_full_queue();
		test_random_mix(950);

		// any late or extra result shows up in the checker during this wait
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
